@@ design/bda_pkg.sv @@
// Shared types and constants for the box-average downsampler.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package bda_pkg;

  // Pixel channel and result position widths.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned ROW_W   = 11;

  // Image height limit and the width of the height register.
  localparam int unsigned H_W     = 12;
  localparam int unsigned H_MAX   = 2048;

  // Configuration port.
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BS_REG_W   = 5;
  localparam int unsigned DIM_REG_W  = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Register reset values.
  localparam logic [BS_REG_W-1:0]  BLOCK_SIZE_RST   = 5'd8;
  localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Control flags carried with each command.
  typedef struct packed {
    logic first_row;  // first row of a block row: overwrite the column sum
    logic emit;       // bottom-right pixel of a block: produce an average
    logic frame_end;  // last block of the frame
  } cmd_ctl_t;

endpackage

`default_nettype wire

@@ design/bda_front.sv @@
// Front end of the box-average downsampler: configuration registers, pixel
// position counters and classification of each pixel into a command.
// Depends on bda_pkg.
`default_nettype none

module bda_front #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [bda_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [bda_pkg::CFG_W-1:0]            cfg_data_i,
  // Pixel input channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [bda_pkg::PIX_W-1:0]            red_in_i,
  input  wire logic [bda_pkg::PIX_W-1:0]            green_in_i,
  input  wire logic [bda_pkg::PIX_W-1:0]            blue_in_i,
  // Command queue write side.
  input  wire logic                                 q_full_i,
  output logic                                      push_o,
  output bda_pkg::cmd_ctl_t                         cmd_ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]              cmd_addr_o,
  output logic [$clog2(MAX_WIDTH)-1:0]              cmd_first_o,
  output logic [bda_pkg::POS_W-1:0]                 cmd_bcol_o,
  output logic [bda_pkg::POS_W-1:0]                 cmd_brow_o,
  output logic [bda_pkg::NUM_CH-1:0][bda_pkg::PIX_W-1:0] cmd_pix_o,
  // Effective block size and block area for the back end.
  output logic [$clog2(MAX_BLOCK+1)-1:0]            bs_o,
  output logic [2*$clog2(MAX_BLOCK+1)-1:0]          area_o
);

  localparam int unsigned COL_AW = $clog2(MAX_WIDTH);
  localparam int unsigned W_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BS_W   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned OFF_W  = $clog2(MAX_BLOCK);
  localparam int unsigned AREA_W = 2 * BS_W;
  localparam int unsigned XW     = ((W_W > BS_W) ? W_W : BS_W) + 2;
  localparam int unsigned YW     = ((bda_pkg::H_W > BS_W) ? bda_pkg::H_W : BS_W) + 2;

  // Configuration registers.
  logic [bda_pkg::BS_REG_W-1:0]  block_size_q;
  logic [bda_pkg::DIM_REG_W-1:0] image_width_q;
  logic [bda_pkg::DIM_REG_W-1:0] image_height_q;

  // Position counters.
  logic [COL_AW-1:0]         pix_col_q, pix_col_d;
  logic [OFF_W-1:0]          off_x_q, off_x_d;
  logic [COL_AW-1:0]         blk_col_q, blk_col_d;
  logic [COL_AW-1:0]         first_col_q, first_col_d;
  logic [bda_pkg::ROW_W-1:0] pix_row_q, pix_row_d;
  logic [OFF_W-1:0]          off_y_q, off_y_d;
  logic [bda_pkg::ROW_W-1:0] blk_row_q, blk_row_d;
  logic [bda_pkg::ROW_W-1:0] first_row_q, first_row_d;

  logic [BS_W-1:0]           bs;
  logic [W_W-1:0]            w_eff;
  logic [bda_pkg::H_W-1:0]   h_eff;
  logic                      accept;
  logic                      col_ok, row_ok, col_last, row_last;
  logic                      last_x, last_y;
  logic [W_W-1:0]            col_nxt;
  logic [bda_pkg::H_W-1:0]   row_nxt;

  // Clamp the registers to their usable ranges.
  always_comb begin
    if (block_size_q == '0) begin
      bs = BS_W'(1);
    end else if (32'(block_size_q) > MAX_BLOCK) begin
      bs = BS_W'(MAX_BLOCK);
    end else begin
      bs = BS_W'(block_size_q);
    end
    if (image_width_q == '0) begin
      w_eff = W_W'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(image_width_q);
    end
    if (image_height_q == '0) begin
      h_eff = bda_pkg::H_W'(1);
    end else if (32'(image_height_q) > bda_pkg::H_MAX) begin
      h_eff = bda_pkg::H_W'(bda_pkg::H_MAX);
    end else begin
      h_eff = image_height_q;
    end
  end

  assign bs_o   = bs;
  assign area_o = AREA_W'(bs) * AREA_W'(bs);

  // Classify the current position against the whole-block area.
  assign col_ok   = (XW'(first_col_q) + XW'(bs)) <= XW'(w_eff);
  assign row_ok   = (YW'(first_row_q) + YW'(bs)) <= YW'(h_eff);
  assign col_last = (XW'(first_col_q) + (XW'(bs) << 1)) > XW'(w_eff);
  assign row_last = (YW'(first_row_q) + (YW'(bs) << 1)) > YW'(h_eff);
  assign last_x   = BS_W'(off_x_q) == (bs - BS_W'(1));
  assign last_y   = BS_W'(off_y_q) == (bs - BS_W'(1));

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && col_ok && row_ok;

  // Command fields for the back end.
  always_comb begin
    cmd_ctl_o.first_row = (off_y_q == '0);
    cmd_ctl_o.emit      = last_x && last_y;
    cmd_ctl_o.frame_end = col_last && row_last;
  end
  assign cmd_addr_o  = pix_col_q;
  assign cmd_first_o = first_col_q;
  assign cmd_bcol_o  = bda_pkg::POS_W'(blk_col_q);
  assign cmd_brow_o  = blk_row_q;
  assign cmd_pix_o   = {red_in_i, green_in_i, blue_in_i};

  // Advance the raster position; any register write restarts the frame.
  always_comb begin
    pix_col_d   = pix_col_q;
    off_x_d     = off_x_q;
    blk_col_d   = blk_col_q;
    first_col_d = first_col_q;
    pix_row_d   = pix_row_q;
    off_y_d     = off_y_q;
    blk_row_d   = blk_row_q;
    first_row_d = first_row_q;
    col_nxt     = W_W'(pix_col_q) + W_W'(1);
    row_nxt     = bda_pkg::H_W'(pix_row_q) + bda_pkg::H_W'(1);
    if (cfg_we_i) begin
      pix_col_d   = '0;
      off_x_d     = '0;
      blk_col_d   = '0;
      first_col_d = '0;
      pix_row_d   = '0;
      off_y_d     = '0;
      blk_row_d   = '0;
      first_row_d = '0;
    end else if (accept) begin
      pix_col_d = COL_AW'(col_nxt);
      if ((BS_W'(off_x_q) + BS_W'(1)) >= bs) begin
        off_x_d     = '0;
        blk_col_d   = blk_col_q + COL_AW'(1);
        first_col_d = COL_AW'(XW'(first_col_q) + XW'(bs));
      end else begin
        off_x_d = off_x_q + OFF_W'(1);
      end
      if (col_nxt >= w_eff) begin
        pix_col_d   = '0;
        off_x_d     = '0;
        blk_col_d   = '0;
        first_col_d = '0;
        pix_row_d   = bda_pkg::ROW_W'(row_nxt);
        if ((BS_W'(off_y_q) + BS_W'(1)) >= bs) begin
          off_y_d     = '0;
          blk_row_d   = blk_row_q + bda_pkg::ROW_W'(1);
          first_row_d = bda_pkg::ROW_W'(YW'(first_row_q) + YW'(bs));
        end else begin
          off_y_d = off_y_q + OFF_W'(1);
        end
        if (row_nxt >= h_eff) begin
          pix_row_d   = '0;
          off_y_d     = '0;
          blk_row_d   = '0;
          first_row_d = '0;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q   <= bda_pkg::BLOCK_SIZE_RST;
      image_width_q  <= bda_pkg::IMAGE_WIDTH_RST;
      image_height_q <= bda_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bda_pkg::REG_BLOCK_SIZE:   block_size_q   <= cfg_data_i[bda_pkg::BS_REG_W-1:0];
        bda_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[bda_pkg::DIM_REG_W-1:0];
        bda_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[bda_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q   <= '0;
      off_x_q     <= '0;
      blk_col_q   <= '0;
      first_col_q <= '0;
      pix_row_q   <= '0;
      off_y_q     <= '0;
      blk_row_q   <= '0;
      first_row_q <= '0;
    end else begin
      pix_col_q   <= pix_col_d;
      off_x_q     <= off_x_d;
      blk_col_q   <= blk_col_d;
      first_col_q <= first_col_d;
      pix_row_q   <= pix_row_d;
      off_y_q     <= off_y_d;
      blk_row_q   <= blk_row_d;
      first_row_q <= first_row_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bda_queue.sv @@
// Small command queue that decouples the front end from the back end.
// Depends on bda_pkg for its depth.
`default_nettype none

module bda_queue #(
  parameter int unsigned DATA_W = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      data_o
);

  localparam int unsigned DEPTH = bda_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill-count update with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/bda_back.sv @@
// Back end of the box-average downsampler: column-sum line store, block
// sweep, serial divider and the output register.
// Depends on bda_pkg.
`default_nettype none

module bda_back #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Command queue read side.
  input  wire logic                                 cmd_valid_i,
  output logic                                      cmd_pop_o,
  input  wire bda_pkg::cmd_ctl_t                    cmd_ctl_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]         cmd_addr_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]         cmd_first_i,
  input  wire logic [bda_pkg::POS_W-1:0]            cmd_bcol_i,
  input  wire logic [bda_pkg::POS_W-1:0]            cmd_brow_i,
  input  wire logic [bda_pkg::NUM_CH-1:0][bda_pkg::PIX_W-1:0] cmd_pix_i,
  // Block geometry.
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0]       bs_i,
  input  wire logic [2*$clog2(MAX_BLOCK+1)-1:0]     area_i,
  // Result channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [bda_pkg::PIX_W-1:0]                 red_avg_o,
  output logic [bda_pkg::PIX_W-1:0]                 green_avg_o,
  output logic [bda_pkg::PIX_W-1:0]                 blue_avg_o,
  output logic [bda_pkg::POS_W-1:0]                 out_column_o,
  output logic [bda_pkg::POS_W-1:0]                 out_row_o,
  output logic                                      frame_end_o
);

  localparam int unsigned COL_AW = $clog2(MAX_WIDTH);
  localparam int unsigned BS_W   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned OFF_W  = $clog2(MAX_BLOCK);
  localparam int unsigned AREA_W = 2 * BS_W;
  localparam int unsigned CSUM_W = $clog2(MAX_BLOCK * 255 + 1);
  localparam int unsigned BSUM_W = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int unsigned DSR_W  = AREA_W + bda_pkg::PIX_W;
  localparam int unsigned DCNT_W = $clog2(bda_pkg::PIX_W);
  localparam int unsigned NCH    = bda_pkg::NUM_CH;
  localparam int unsigned PW     = bda_pkg::PIX_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RMW    = 6'b000010,
    S_SWEEP  = 6'b000100,
    S_SWLAST = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  // Line store of per-column channel sums.
  logic [NCH-1:0][CSUM_W-1:0] mem_q [MAX_WIDTH];
  logic [NCH-1:0][CSUM_W-1:0] rd_data_q;
  logic [NCH-1:0][CSUM_W-1:0] wr_data;
  logic [COL_AW-1:0]          mem_raddr;
  logic                       mem_we;

  // Current command.
  bda_pkg::cmd_ctl_t          ctl_q;
  logic [COL_AW-1:0]          addr_q;
  logic [COL_AW-1:0]          first_q;
  logic [bda_pkg::POS_W-1:0]  bcol_q;
  logic [bda_pkg::POS_W-1:0]  brow_q;
  logic [NCH-1:0][PW-1:0]     pix_q;

  // Sweep, accumulate and divide.
  logic [OFF_W-1:0]           k_q, k_d;
  logic                       sweep_vld_q, sweep_vld_d;
  logic [NCH-1:0][BSUM_W-1:0] acc_q, acc_d;
  logic [DSR_W-1:0]           dsr_q, dsr_d;
  logic [DCNT_W-1:0]          dcnt_q, dcnt_d;
  logic [NCH-1:0][PW-1:0]     quot_q, quot_d;
  logic [COL_AW-1:0]          sweep_addr;
  logic                       last_k;
  logic                       out_free;
  logic                       out_load;

  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign sweep_addr = COL_AW'((COL_AW + 1)'(first_q) + (COL_AW + 1)'(k_q));
  assign last_k     = BS_W'(k_q) == (bs_i - BS_W'(1));
  assign mem_raddr  = (state_q == S_IDLE) ? cmd_addr_i : sweep_addr;
  assign mem_we     = (state_q == S_RMW);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  // New column sum: restart on the first row of a block row, else accumulate.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (ctl_q.first_row) begin
        wr_data[c] = CSUM_W'(pix_q[c]);
      end else begin
        wr_data[c] = rd_data_q[c] + CSUM_W'(pix_q[c]);
      end
    end
  end

  // Line store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= wr_data;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // Sequencer for one command.
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    sweep_vld_d = 1'b0;
    acc_d       = acc_q;
    dsr_d       = dsr_q;
    dcnt_d      = dcnt_q;
    quot_d      = quot_q;

    // Column sums arrive in the cycle after their read is issued.
    if (sweep_vld_q) begin
      for (int c = 0; c < NCH; c++) begin
        acc_d[c] = acc_q[c] + BSUM_W'(rd_data_q[c]);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        if (ctl_q.emit) begin
          k_d     = '0;
          acc_d   = '0;
          state_d = S_SWEEP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        sweep_vld_d = 1'b1;
        k_d         = k_q + OFF_W'(1);
        if (last_k) begin
          state_d = S_SWLAST;
        end
      end
      S_SWLAST: begin
        dsr_d   = DSR_W'(area_i) << (PW - 1);
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle for each channel.
        for (int c = 0; c < NCH; c++) begin
          if (DSR_W'(acc_q[c]) >= dsr_q) begin
            acc_d[c]  = BSUM_W'(DSR_W'(acc_q[c]) - dsr_q);
            quot_d[c] = {quot_q[c][PW-2:0], 1'b1};
          end else begin
            quot_d[c] = {quot_q[c][PW-2:0], 1'b0};
          end
        end
        dsr_d  = dsr_q >> 1;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (32'(dcnt_q) == PW - 1) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sweep_vld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_vld_q <= sweep_vld_d;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    acc_q  <= acc_d;
    dsr_q  <= dsr_d;
    dcnt_q <= dcnt_d;
    quot_q <= quot_d;
  end

  // Capture the command taken from the queue.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      ctl_q   <= cmd_ctl_i;
      addr_q  <= cmd_addr_i;
      first_q <= cmd_first_i;
      bcol_q  <= cmd_bcol_i;
      brow_q  <= cmd_brow_i;
      pix_q   <= cmd_pix_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_avg_o    <= quot_q[2];
      green_avg_o  <= quot_q[1];
      blue_avg_o   <= quot_q[0];
      out_column_o <= bcol_q;
      out_row_o    <= brow_q;
      frame_end_o  <= ctl_q.frame_end;
    end
  end

endmodule

`default_nettype wire

@@ design/box_average_downsampler.sv @@
// Top level of the box-average downsampler: front end, command queue, back end.
// Depends on bda_pkg, bda_front, bda_queue and bda_back.
//
//   Channel   Direction  Handshake                 Beat contents
//   -------   ---------  ------------------------  -------------------------------
//   pixel     in         in_valid_i / in_stall_o   red_in_i, green_in_i, blue_in_i
//   average   out        out_valid_o / out_stall_i red/green/blue_avg_o, out_column_o,
//                                                  out_row_o, frame_end_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The front end takes one pixel beat per cycle while the four-entry command queue
// has room. The back end reads and then writes the line store for each pixel
// (states S_IDLE and S_RMW); a block's bottom-right pixel adds the column sweep
// (one line-store read per cycle) and the eight-step divider.
// Reset clears the counters, configuration and control state, not the line store.
// A stalled result holds in the output register while pixels fill the command queue.
`default_nettype none

module box_average_downsampler #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bda_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bda_pkg::PIX_W-1:0]     red_in_i,
  input  wire logic [bda_pkg::PIX_W-1:0]     green_in_i,
  input  wire logic [bda_pkg::PIX_W-1:0]     blue_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bda_pkg::PIX_W-1:0]          red_avg_o,
  output logic [bda_pkg::PIX_W-1:0]          green_avg_o,
  output logic [bda_pkg::PIX_W-1:0]          blue_avg_o,
  output logic [bda_pkg::POS_W-1:0]          out_column_o,
  output logic [bda_pkg::POS_W-1:0]          out_row_o,
  output logic                               frame_end_o
);

  localparam int unsigned COL_AW = $clog2(MAX_WIDTH);
  localparam int unsigned BS_W   = $clog2(MAX_BLOCK + 1);
  localparam int unsigned AREA_W = 2 * BS_W;
  localparam int unsigned CTL_W  = $bits(bda_pkg::cmd_ctl_t);
  localparam int unsigned DATA_W = CTL_W + 2 * COL_AW + 2 * bda_pkg::POS_W
                                   + bda_pkg::NUM_CH * bda_pkg::PIX_W;

  // Command fields on the front side.
  bda_pkg::cmd_ctl_t                               f_ctl;
  logic [COL_AW-1:0]                               f_addr, f_first;
  logic [bda_pkg::POS_W-1:0]                       f_bcol, f_brow;
  logic [bda_pkg::NUM_CH-1:0][bda_pkg::PIX_W-1:0]  f_pix;

  // Command fields on the back side.
  bda_pkg::cmd_ctl_t                               b_ctl;
  logic [COL_AW-1:0]                               b_addr, b_first;
  logic [bda_pkg::POS_W-1:0]                       b_bcol, b_brow;
  logic [bda_pkg::NUM_CH-1:0][bda_pkg::PIX_W-1:0]  b_pix;

  logic              push, full, pop, q_valid;
  logic [DATA_W-1:0] q_wdata, q_rdata;
  logic [BS_W-1:0]   bs;
  logic [AREA_W-1:0] area;

  bda_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .q_full_i    (full),
    .push_o      (push),
    .cmd_ctl_o   (f_ctl),
    .cmd_addr_o  (f_addr),
    .cmd_first_o (f_first),
    .cmd_bcol_o  (f_bcol),
    .cmd_brow_o  (f_brow),
    .cmd_pix_o   (f_pix),
    .bs_o        (bs),
    .area_o      (area)
  );

  // Pack and unpack the command word around the queue.
  assign q_wdata = {f_ctl, f_addr, f_first, f_bcol, f_brow, f_pix};
  assign {b_ctl, b_addr, b_first, b_bcol, b_brow, b_pix} = q_rdata;

  bda_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  bda_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_pop_o    (pop),
    .cmd_ctl_i    (b_ctl),
    .cmd_addr_i   (b_addr),
    .cmd_first_i  (b_first),
    .cmd_bcol_i   (b_bcol),
    .cmd_brow_i   (b_brow),
    .cmd_pix_i    (b_pix),
    .bs_i         (bs),
    .area_i       (area),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_avg_o    (red_avg_o),
    .green_avg_o  (green_avg_o),
    .blue_avg_o   (blue_avg_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the box-average downsampler: raster pixel beats in,
// block averages out. Depends on bda_pkg and box_average_downsampler only.
module testbench;

  localparam int unsigned LINE_LEN     = 2048;
  localparam int unsigned BLOCK_MAX    = 16;
  localparam int unsigned HEIGHT_MAX   = bda_pkg::H_MAX;
  localparam logic [bda_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_PIXELS = 1300;
  localparam int unsigned QUIET_PIXELS  = 300;
  localparam int unsigned SAT_PIXELS    = 40;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [bda_pkg::PIX_W-1:0] red;
    logic [bda_pkg::PIX_W-1:0] green;
    logic [bda_pkg::PIX_W-1:0] blue;
    logic [bda_pkg::POS_W-1:0] column;
    logic [bda_pkg::POS_W-1:0] row;
    logic                      frame_end;
  } block_avg_t;

  // Tracks the block position and column sums and queues the averages the block owes.
  class average_tracker;
    logic [bda_pkg::BS_REG_W-1:0]  block_size;
    logic [bda_pkg::DIM_REG_W-1:0] image_width;
    logic [bda_pkg::DIM_REG_W-1:0] image_height;
    int unsigned sum_red[LINE_LEN];
    int unsigned sum_green[LINE_LEN];
    int unsigned sum_blue[LINE_LEN];
    int unsigned col, row, in_x, in_y, blk_x, blk_y;
    block_avg_t expected_averages[$];
    int unsigned pixels, averages, mismatches;

    function new();
      block_size   = bda_pkg::BLOCK_SIZE_RST;
      image_width  = bda_pkg::IMAGE_WIDTH_RST;
      image_height = bda_pkg::IMAGE_HEIGHT_RST;
      pixels = 0;
      averages = 0;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col = 0;
      row = 0;
      in_x = 0;
      in_y = 0;
      blk_x = 0;
      blk_y = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Any write, even to the spare index, starts a new frame.
    function void write_reg(logic [bda_pkg::CFG_IDX_W-1:0] idx,
                            logic [bda_pkg::CFG_W-1:0] data);
      case (idx)
        bda_pkg::REG_BLOCK_SIZE:   block_size   = data[bda_pkg::BS_REG_W-1:0];
        bda_pkg::REG_IMAGE_WIDTH:  image_width  = data[bda_pkg::DIM_REG_W-1:0];
        bda_pkg::REG_IMAGE_HEIGHT: image_height = data[bda_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
      restart_frame();
    endfunction

    function void take_pixel(logic [bda_pkg::PIX_W-1:0] r, logic [bda_pkg::PIX_W-1:0] g,
                             logic [bda_pkg::PIX_W-1:0] b);
      int unsigned bs, w, h, blocks_x, blocks_y, first, area, k;
      int unsigned acc_r, acc_g, acc_b;
      block_avg_t avg;
      bs = clamp(32'(block_size), BLOCK_MAX);
      w = clamp(32'(image_width), LINE_LEN);
      h = clamp(32'(image_height), HEIGHT_MAX);
      blocks_x = w / bs;
      blocks_y = h / bs;
      pixels++;

      // Accumulate only inside whole blocks; emit on the bottom-right pixel.
      if (blk_x < blocks_x && blk_y < blocks_y) begin
        if (in_y == 0) begin
          sum_red[col] = 32'(r);
          sum_green[col] = 32'(g);
          sum_blue[col] = 32'(b);
        end else begin
          sum_red[col] += 32'(r);
          sum_green[col] += 32'(g);
          sum_blue[col] += 32'(b);
        end
        if (in_x == bs - 1 && in_y == bs - 1) begin
          acc_r = 0;
          acc_g = 0;
          acc_b = 0;
          first = blk_x * bs;
          area = bs * bs;
          for (k = 0; k < bs; k++) begin
            acc_r += sum_red[first + k];
            acc_g += sum_green[first + k];
            acc_b += sum_blue[first + k];
          end
          avg.red = bda_pkg::PIX_W'(acc_r / area);
          avg.green = bda_pkg::PIX_W'(acc_g / area);
          avg.blue = bda_pkg::PIX_W'(acc_b / area);
          avg.column = bda_pkg::POS_W'(blk_x);
          avg.row = bda_pkg::POS_W'(blk_y);
          avg.frame_end = (blk_x == blocks_x - 1) && (blk_y == blocks_y - 1);
          expected_averages = {expected_averages, avg};
        end
      end

      // Advance the raster position; wrap at the end of a row and of the frame.
      col++;
      in_x++;
      if (in_x >= bs) begin
        in_x = 0;
        blk_x++;
      end
      if (col >= w) begin
        col = 0;
        in_x = 0;
        blk_x = 0;
        row++;
        in_y++;
        if (in_y >= bs) begin
          in_y = 0;
          blk_y++;
        end
        if (row >= h) restart_frame();
      end
    endfunction

    function void check_average(block_avg_t got);
      block_avg_t want;
      if (expected_averages.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected average rgb %0d %0d %0d at (%0d,%0d) end %0d",
                   got.red, got.green, got.blue, got.column, got.row, got.frame_end);
        return;
      end
      want = expected_averages.pop_front();
      averages++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.column !== want.column || got.row !== want.row ||
          got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: average %0d expected rgb %0d %0d %0d at (%0d,%0d) end %0d",
                   averages, want.red, want.green, want.blue, want.column, want.row,
                   want.frame_end);
          $display("       got                rgb %0d %0d %0d at (%0d,%0d) end %0d",
                   got.red, got.green, got.blue, got.column, got.row, got.frame_end);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_averages.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [bda_pkg::CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [bda_pkg::CFG_W-1:0]       cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [bda_pkg::PIX_W-1:0]       red_in = '0;
  logic [bda_pkg::PIX_W-1:0]       green_in = '0;
  logic [bda_pkg::PIX_W-1:0]       blue_in = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [bda_pkg::PIX_W-1:0]       red_avg, green_avg, blue_avg;
  logic [bda_pkg::POS_W-1:0]       out_column, out_row;
  logic                            frame_end;

  average_tracker tracker;
  bit             idle_on = 1'b1;
  int unsigned    hold_requests = 0;
  int unsigned    reg_writes = 0;

  box_average_downsampler #(
    .MAX_WIDTH(LINE_LEN),
    .MAX_BLOCK(BLOCK_MAX)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_avg_o   (red_avg),
    .green_avg_o (green_avg),
    .blue_avg_o  (blue_avg),
    .out_column_o(out_column),
    .out_row_o   (out_row),
    .frame_end_o (frame_end)
  );

  // Free-running clock.
  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // Hard cycle limit in case the block hangs.
  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ERROR: no completion within %0d cycles", CYCLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  // Result side: checks every accepted beat and stalls in random bursts or long holds.
  initial begin : result_sink
    int unsigned burst_left;
    int unsigned hold_left;
    int unsigned holds_served;
    block_avg_t got;
    burst_left = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.red = red_avg;
        got.green = green_avg;
        got.blue = blue_avg;
        got.column = out_column;
        got.row = out_row;
        got.frame_end = frame_end;
        tracker.check_average(got);
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (burst_left > 0) begin
        burst_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(1, 18);
      end
      out_stall <= (hold_left > 0) || (burst_left > 0);
    end
  end

  // Offers one pixel beat, after an optional idle burst, and waits for acceptance.
  task automatic send_pixel(input logic [bda_pkg::PIX_W-1:0] r,
                            input logic [bda_pkg::PIX_W-1:0] g,
                            input logic [bda_pkg::PIX_W-1:0] b);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_pixel(r, g, b);
  endtask

  // Stops offering pixels until every owed average has arrived.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Leaves the block idle: results drained and pixels without results worked off.
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after its last write.
  task automatic write_reg(input logic [bda_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bda_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    reg_writes++;
  endtask

  // Writes the registers selected by their bit in the mask while the block is idle.
  task automatic load_config(input logic [2:0] which,
                             input logic [bda_pkg::CFG_W-1:0] bs_val,
                             input logic [bda_pkg::CFG_W-1:0] w_val,
                             input logic [bda_pkg::CFG_W-1:0] h_val);
    settle();
    if (which[bda_pkg::REG_BLOCK_SIZE]) write_reg(bda_pkg::REG_BLOCK_SIZE, bs_val);
    if (which[bda_pkg::REG_IMAGE_WIDTH]) write_reg(bda_pkg::REG_IMAGE_WIDTH, w_val);
    if (which[bda_pkg::REG_IMAGE_HEIGHT]) write_reg(bda_pkg::REG_IMAGE_HEIGHT, h_val);
    cfg_we <= 1'b0;
  endtask

  // A write to the unused index only restarts the frame.
  task automatic spare_write();
    settle();
    write_reg(REG_SPARE, bda_pkg::CFG_W'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [bda_pkg::PIX_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bda_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [bda_pkg::CFG_W-1:0] pick_block_size();
    logic [bda_pkg::CFG_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = bda_pkg::CFG_W'($urandom_range(17, 31));
      2: v = bda_pkg::CFG_W'(16);
      default: v = bda_pkg::CFG_W'($urandom_range(1, 6));
    endcase
    // Bits above the register width must be ignored.
    if ($urandom_range(0, 3) == 0)
      v[bda_pkg::CFG_W-1:bda_pkg::BS_REG_W] =
        (bda_pkg::CFG_W - bda_pkg::BS_REG_W)'($urandom_range(0, 127));
    return v;
  endfunction

  function automatic logic [bda_pkg::CFG_W-1:0] pick_width();
    logic [bda_pkg::CFG_W-1:0] v;
    if ($urandom_range(0, 19) == 0) v = '0;
    else v = bda_pkg::CFG_W'($urandom_range(1, 40));
    return v;
  endfunction

  function automatic logic [bda_pkg::CFG_W-1:0] pick_height();
    logic [bda_pkg::CFG_W-1:0] v;
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = bda_pkg::CFG_W'(2048);
      2: v = bda_pkg::CFG_W'($urandom_range(2049, 4095));
      default: v = bda_pkg::CFG_W'($urandom_range(1, 40));
    endcase
    return v;
  endfunction

  // Random pixels with an occasional pause until all results are in.
  task automatic send_random(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) == 0) wait_results();
      send_pixel(pick_level(), pick_level(), pick_level());
    end
  endtask

  // Main sequence: reset, directed frames, pressure phases, random phases, drain.
  initial begin : stimulus
    int unsigned k;
    int unsigned count;
    int unsigned random_sent;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset block size of 8 on an 8-pixel-wide image gives one average after 64 pixels.
    load_config(3'b010, '0, 12'd8, '0);
    for (k = 0; k < 66; k++) send_pixel(8'd255, k[7:0], 8'd0);

    // Two 2x2 blocks with extreme and truncating values; upper data bits set.
    load_config(3'b111, 12'hFE2, 12'd4, 12'd2);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd2);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd2, 8'd254, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd3);
    send_pixel(8'd255, 8'd0, 8'd4);
    send_pixel(8'd3, 8'd253, 8'd0);
    send_pixel(8'd4, 8'd255, 8'd255);

    // A frame cut short by a write to the unused index.
    send_random(3);
    spare_write();
    send_random(8);

    // Zero sizes act as one: every pixel is a whole frame.
    load_config(3'b111, 12'd0, 12'd0, 12'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd127, 8'd1);

    // An image smaller than one block never produces an average.
    load_config(3'b111, 12'd5, 12'd4, 12'd4);
    send_random(6);

    // Long output hold while pixels keep coming, so the input stalls.
    idle_on = 1'b0;
    load_config(3'b111, 12'd1, 12'd6, 12'd4);
    hold_requests++;
    send_random(80);
    idle_on = 1'b1;

    // Oversized block size saturates at sixteen: one average per frame.
    load_config(3'b111, 12'd31, 12'd17, 12'd16);
    send_random(17 * 16 + 4);

    // Oversized width: single-pixel blocks along one long row.
    load_config(3'b111, 12'd1, 12'd4095, 12'd1);
    send_random(SAT_PIXELS);

    // Oversized height: single-pixel blocks down one long column.
    load_config(3'b111, 12'd1, 12'd1, bda_pkg::CFG_W'($urandom_range(2049, 4095)));
    send_random(SAT_PIXELS);

    // Random settings and frame lengths; the last stretch runs without idling.
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if (random_sent >= RANDOM_PIXELS - QUIET_PIXELS) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) spare_write();
      else load_config(3'($urandom_range(1, 7)), pick_block_size(), pick_width(),
                       pick_height());
      count = $urandom_range(1, 160);
      send_random(count);
      random_sent += count;
    end

    // Drain and look for stray results.
    idle_on = 1'b0;
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixels, %0d block averages and %0d register writes,",
             tracker.pixels, tracker.averages, reg_writes);
    $display("with degenerate and saturated sizes, frame restarts and a long output hold.");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("ERROR: %0d mismatches, %0d averages missing",
               tracker.mismatches, tracker.pending());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
